// ===== rtl/core/edf_pkg.sv =====
// Shared types and constants for the EDF ready queue core.
// No dependencies.
`timescale 1ns / 1ps
package edf_pkg;
   localparam int MAX_THREADS = 32;

   localparam logic [2:0] CMD_SET_PARAMS = 3'd0;
   localparam logic [2:0] CMD_RELEASE    = 3'd1;
   localparam logic [2:0] CMD_COMPLETE   = 3'd2;
   localparam logic [2:0] CMD_TICK       = 3'd3;
   localparam logic [2:0] CMD_PICK       = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_NO_THR  = 2'd2;

   localparam logic [1:0] RSN_NONE     = 2'd0;
   localparam logic [1:0] RSN_BUDGET   = 2'd1;
   localparam logic [1:0] RSN_DEADLINE = 2'd2;

   localparam logic [47:0] DL_INVALID = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]  command;
      logic [4:0]  thread_id;
      logic [47:0] now_time;
      logic [31:0] budget;
      logic [31:0] job_period;
      logic [31:0] rel_deadline;
      logic        periodic;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        head_valid;
      logic [4:0]  head_thread;
      logic        reschedule;
      logic [1:0]  resched_reason;
      logic [15:0] overruns;
   } rsp_type;

   // Saturating now + 32-bit offset.
   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? DL_INVALID : s[47:0];
   endfunction
endpackage

// ===== rtl/core/edf_deadline_ready_queue_core.sv =====
// EDF ready queue core: per-thread timing tables and a deadline-sorted queue.
// Depends on edf_pkg.
//
// Usage: present one request on req_* (valid/ready). Each request yields
// exactly one response on rsp_*. The core handles one request at a time:
// req_ready is high only while the sequencer is idle.
// Each request passes an execute step, then the response step; set_params,
// tick, pick, unknown codes and any request that leaves the queue alone go
// straight from one to the other. Release of an unqueued thread searches and
// shifts with one deadline comparator, one entry per cycle. A periodic complete
// that removes its thread walks to its entry and shifts later entries down.
// Release or re-sorting set_params of a queued thread removes then inserts.
// The sequencer returns to idle when the response is loaded, so the queue walk
// sets the throughput: no new request is taken until the last one is through.
// Reset clears all timing tables to their defaults at once (flip-flops) and
// empties the queue; no clearing pass is needed.
// A stalled receiver holds the response register; a request taken meanwhile
// runs its walk and then waits until the previous response has been taken.
`timescale 1ns / 1ps
module edf_deadline_ready_queue_core #(
   parameter longint DEFAULT_BUDGET = 10,
   parameter longint DEFAULT_PERIOD = 100
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  edf_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output edf_pkg::rsp_type  rsp_data
);
   localparam int NT = edf_pkg::MAX_THREADS;
   localparam int QW = $clog2(NT);
   localparam int CW = $clog2(NT + 1);
   localparam logic [31:0] DEF_BUD = DEFAULT_BUDGET[31:0];
   localparam logic [31:0] DEF_PER = DEFAULT_PERIOD[31:0];

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_RFND = 3'd2;   // search queued entry, then shift down
   localparam logic [2:0] S_RSHF = 3'd3;
   localparam logic [2:0] S_IFND = 3'd4;   // search insertion point
   localparam logic [2:0] S_ISHF = 3'd5;   // shift up, then place
   localparam logic [2:0] S_RESP = 3'd6;

   logic [2:0] state_ff;

   logic [47:0] abs_dl_ff   [NT];
   logic [31:0] rel_ff      [NT];
   logic [31:0] per_ff      [NT];
   logic [31:0] bud_ff      [NT];
   logic [31:0] run_ff      [NT];
   logic [47:0] nrel_ff     [NT];
   logic [15:0] ovr_ff      [NT];
   logic [NT-1:0] perf_ff, edf_ff, qd_ff;
   logic [QW-1:0] order_ff  [NT];
   logic [CW-1:0] count_ff;

   edf_pkg::req_type req_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] ins_pt_ff;
   logic          do_ins_ff;
   logic [1:0]    status_ff, reason_ff;
   logic          resched_ff;
   logic          rsp_valid_ff;
   edf_pkg::rsp_type rsp_ff;

   logic          tvalid;
   logic [QW-1:0] t;
   assign tvalid = (32'(req_ff.thread_id) < 32'(NT));
   assign t = req_ff.thread_id[QW-1:0];

   logic [QW-1:0] idx_q;
   assign idx_q = idx_ff[QW-1:0];
   logic [QW-1:0] entry;
   assign entry = order_ff[idx_q];
   logic later;
   assign later = abs_dl_ff[t] < abs_dl_ff[entry];

   // Runtime after one more tick, saturating.
   logic [31:0] run_inc;
   assign run_inc = (run_ff[t] != '1) ? run_ff[t] + 32'd1 : run_ff[t];

   logic set_bad;
   assign set_bad = (req_ff.job_period != 32'd0 && req_ff.budget > req_ff.job_period)
                    || req_ff.rel_deadline < req_ff.budget;

   // Outcome of the execute step.
   logic [1:0] exec_status, exec_reason;
   logic       exec_resched, exec_ins;
   logic [2:0] exec_next;

   always_comb begin
      exec_status  = edf_pkg::ST_OK;
      exec_resched = 1'b0;
      exec_reason  = edf_pkg::RSN_NONE;
      exec_ins     = 1'b0;
      exec_next    = S_RESP;
      if (req_ff.command > edf_pkg::CMD_PICK) begin
         exec_status = edf_pkg::ST_INVALID;
      end else if (req_ff.command == edf_pkg::CMD_PICK) begin
         exec_status = edf_pkg::ST_OK;
      end else if (!tvalid) begin
         exec_status = edf_pkg::ST_NO_THR;
      end else begin
         case (req_ff.command)
            edf_pkg::CMD_SET_PARAMS: begin
               if (set_bad) begin
                  exec_status = edf_pkg::ST_INVALID;
               end else if (abs_dl_ff[t] == edf_pkg::DL_INVALID && qd_ff[t]) begin
                  exec_ins  = 1'b1;
                  exec_next = S_RFND;
               end
            end
            edf_pkg::CMD_RELEASE: begin
               exec_ins  = 1'b1;
               exec_next = qd_ff[t] ? S_RFND : S_IFND;
            end
            edf_pkg::CMD_COMPLETE: begin
               if (perf_ff[t] && qd_ff[t]) exec_next = S_RFND;
            end
            edf_pkg::CMD_TICK: begin
               if (edf_ff[t]) begin
                  if (run_inc >= bud_ff[t]) begin
                     exec_resched = 1'b1;
                     exec_reason  = edf_pkg::RSN_BUDGET;
                  end else if (req_ff.now_time >= abs_dl_ff[t]) begin
                     exec_resched = 1'b1;
                     exec_reason  = edf_pkg::RSN_DEADLINE;
                  end
               end
            end
            default: exec_status = edf_pkg::ST_INVALID;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         perf_ff      <= '0;
         edf_ff       <= '0;
         qd_ff        <= '0;
         for (int i = 0; i < NT; i++) begin
            abs_dl_ff[i] <= edf_pkg::DL_INVALID;
            rel_ff[i]    <= DEF_PER;
            per_ff[i]    <= DEF_PER;
            bud_ff[i]    <= DEF_BUD;
            run_ff[i]    <= '0;
            nrel_ff[i]   <= '0;
            ovr_ff[i]    <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff   <= req_data;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               status_ff  <= exec_status;
               resched_ff <= exec_resched;
               reason_ff  <= exec_reason;
               do_ins_ff  <= exec_ins;
               idx_ff     <= '0;
               state_ff   <= exec_next;
               // Update the thread tables.
               if (tvalid && req_ff.command <= edf_pkg::CMD_TICK) begin
                  case (req_ff.command)
                     edf_pkg::CMD_SET_PARAMS: begin
                        if (!set_bad) begin
                           bud_ff[t]  <= req_ff.budget;
                           per_ff[t]  <= req_ff.job_period;
                           rel_ff[t]  <= req_ff.rel_deadline;
                           perf_ff[t] <= req_ff.periodic;
                           edf_ff[t]  <= 1'b1;
                           if (abs_dl_ff[t] == edf_pkg::DL_INVALID) begin
                              abs_dl_ff[t] <= edf_pkg::sat_add48(req_ff.now_time,
                                                                 req_ff.rel_deadline);
                              nrel_ff[t]   <= edf_pkg::sat_add48(req_ff.now_time,
                                                                 req_ff.job_period);
                           end
                        end
                     end
                     edf_pkg::CMD_RELEASE: begin
                        abs_dl_ff[t] <= edf_pkg::sat_add48(req_ff.now_time, rel_ff[t]);
                        run_ff[t]    <= '0;
                        if (perf_ff[t])
                           nrel_ff[t] <= edf_pkg::sat_add48(req_ff.now_time, per_ff[t]);
                     end
                     edf_pkg::CMD_TICK: begin
                        if (edf_ff[t]) begin
                           run_ff[t] <= run_inc;
                           if (run_inc < bud_ff[t] && req_ff.now_time >= abs_dl_ff[t]
                               && ovr_ff[t] != '1)
                              ovr_ff[t] <= ovr_ff[t] + 16'd1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            // Walk to this thread's entry.
            S_RFND: begin
               if (entry == t) state_ff <= S_RSHF;
               else idx_ff <= idx_ff + 1'b1;
            end
            // Shift later entries down one slot.
            S_RSHF: begin
               if (idx_ff + 1'b1 < count_ff) begin
                  order_ff[idx_q] <= order_ff[QW'(idx_ff + 1'b1)];
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  count_ff <= count_ff - 1'b1;
                  qd_ff[t] <= 1'b0;
                  idx_ff   <= '0;
                  state_ff <= do_ins_ff ? S_IFND : S_RESP;
               end
            end
            // Advance past entries with deadline not later than ours.
            S_IFND: begin
               if (idx_ff < count_ff && !later) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  do_ins_ff <= 1'b0;
                  idx_ff    <= count_ff;
                  state_ff  <= S_ISHF;
                  ins_pt_ff <= idx_ff;
               end
            end
            // Shift entries up from the tail, then place the thread.
            S_ISHF: begin
               if (idx_ff > ins_pt_ff) begin
                  order_ff[QW'(idx_ff)] <= order_ff[QW'(idx_ff - 1'b1)];
                  idx_ff <= idx_ff - 1'b1;
               end else begin
                  order_ff[QW'(idx_ff)] <= t;
                  count_ff <= count_ff + 1'b1;
                  qd_ff[t] <= 1'b1;
                  state_ff <= S_RESP;
               end
            end
            // Hold until the response register is free.
            S_RESP: begin
               if (!rsp_valid_ff) begin
                  rsp_ff.status         <= status_ff;
                  rsp_ff.head_valid     <= (count_ff != '0);
                  rsp_ff.head_thread    <= (count_ff != '0) ? 5'(order_ff[0]) : 5'd0;
                  rsp_ff.reschedule     <= resched_ff;
                  rsp_ff.resched_reason <= reason_ff;
                  rsp_ff.overruns       <= tvalid ? ovr_ff[t] : 16'd0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
